[sv/sqcg_pkg.sv]
// Shared types, constants and arithmetic helpers for the sprite quad corner generator.
`default_nettype none
package sqcg_pkg;

	localparam int COORD_BITS = 24;
	localparam int ANGLE_BITS = 16;
	localparam int OFS_BITS   = COORD_BITS + 1;   // doubled-unit corner offsets
	localparam int MAG_BITS   = 17;               // Q16 magnitude, 65536 = 1.0
	localparam int TRIG_BITS  = MAG_BITS + 1;     // signed sine/cosine
	localparam int PROD_BITS  = OFS_BITS + TRIG_BITS;
	localparam int NUM_CELLS  = 3;

	typedef logic [MAG_BITS-1:0] mag_t;

	localparam mag_t SIN_A1  = 17'd102944;
	localparam mag_t SIN_A3  = 17'd42334;
	localparam mag_t SIN_A5  = 17'd5223;
	localparam mag_t SIN_A7  = 17'd297;
	localparam mag_t Q16_ONE = 17'd65536;

	// Horner coefficients in chain order
	localparam mag_t HORNER_COEF [NUM_CELLS] = '{SIN_A5, SIN_A3, SIN_A1};

	typedef enum logic [2:0] {
		ROT_NONE  = 3'b001,
		ROT_PLUS  = 3'b010,
		ROT_MINUS = 3'b100
	} rot_t;

	typedef struct packed {
		logic [3:0]                   anchor_mode;
		logic signed [COORD_BITS-1:0] anchor_x;
		logic signed [COORD_BITS-1:0] anchor_y;
		logic [COORD_BITS-2:0]        width;
		logic [COORD_BITS-2:0]        height;
		logic [ANGLE_BITS-1:0]        angle;
	} item_t;

	typedef struct packed {
		logic signed [COORD_BITS-1:0] top_left_x;
		logic signed [COORD_BITS-1:0] top_left_y;
		logic signed [COORD_BITS-1:0] top_right_x;
		logic signed [COORD_BITS-1:0] top_right_y;
		logic signed [COORD_BITS-1:0] bottom_left_x;
		logic signed [COORD_BITS-1:0] bottom_left_y;
		logic signed [COORD_BITS-1:0] bottom_right_x;
		logic signed [COORD_BITS-1:0] bottom_right_y;
	} corners_t;

	typedef struct packed {
		logic signed [COORD_BITS-1:0] ax;
		logic signed [COORD_BITS-1:0] ay;
		logic signed [OFS_BITS-1:0]   xo0;
		logic signed [OFS_BITS-1:0]   xo1;
		logic signed [OFS_BITS-1:0]   yo0;
		logic signed [OFS_BITS-1:0]   yo1;
		rot_t                         rot;
	} geom_t;

	// lane 0 is sine, lane 1 is cosine
	typedef struct packed {
		geom_t      g;
		mag_t [1:0] x;
		logic [1:0] neg;
		mag_t [1:0] z;
		mag_t [1:0] p;
	} stage_t;

	// (a*b) rounded half up to Q16
	function automatic mag_t mulq16(input mag_t a, input mag_t b);
		logic [2*MAG_BITS-1:0] pr;
		pr = {{MAG_BITS{1'b0}}, a} * {{MAG_BITS{1'b0}}, b} + (2*MAG_BITS)'(32768);
		return pr[16 +: MAG_BITS];
	endfunction

endpackage
`default_nettype wire

[sv/sqcg_horner_cell.sv]
// One Horner cell of the sine polynomial chain: p <= COEF - p*z, both lanes.
`default_nettype none
module sqcg_horner_cell #(
	parameter sqcg_pkg::mag_t COEF = sqcg_pkg::SIN_A5
) (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            in_valid,
	input  wire sqcg_pkg::stage_t in_data,
	output logic                 in_ready,
	output logic                 out_valid,
	output sqcg_pkg::stage_t     out_data,
	input  wire logic            out_ready
);
	import sqcg_pkg::*;

	stage_t nxt;

	assign in_ready = !out_valid || out_ready;

	always_comb begin
		nxt = in_data;
		for (int i = 0; i < 2; i++) begin
			nxt.p[i] = COEF - mulq16(in_data.p[i], in_data.z[i]);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (in_ready) begin
			out_valid <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready) begin
			out_data <= nxt;
		end
	end

endmodule
`default_nettype wire

[sv/sprite_quad_corner_generator_unit.sv]
// Top level of the sprite quad corner generator: decode, sine chain, rotate, saturate.
// Takes one sprite word per cycle while item_stall is low and returns its four corners
// (TL, TR, BL, BR, y down). Every stage holds one word, so the unit keeps a word in
// flight in each stage; throughput is one word per clock while the output is not
// stalled. The stages are anchor decode, the sine polynomial chain (square, three
// Horner cells, final scale), the rotate multiply and the round/saturate stage. A stage
// moves whenever the one after it is empty or moving, so bubbles are squeezed out and
// item_stall rises only when all eight stages hold words and the output word is stalled.
`default_nettype none
module sprite_quad_corner_generator_unit (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             item_valid,
	output logic                  item_stall,
	input  wire sqcg_pkg::item_t  item,
	output logic                  corners_valid,
	input  wire logic             corners_stall,
	output sqcg_pkg::corners_t    corners
);
	import sqcg_pkg::*;

	localparam int SUM_BITS = PROD_BITS + 2;

	// ---------------- stage 1: anchor decode and angle folding ----------------
	stage_t d1, st_s1;
	logic   v_s1, rdy_s1;

	logic [1:0] row, col;
	logic       defined;
	logic [31:0] turn;
	logic [1:0]  quad [2];
	logic [15:0] frac;
	logic signed [OFS_BITS-1:0] w1, w2, h1, h2;

	always_comb begin
		defined = 1'b1;
		d1      = '0;
		d1.g.rot = ROT_NONE;
		row = 2'd0;
		col = 2'd0;
		unique case (item.anchor_mode)
			4'd0:  begin row = 2'd0; col = 2'd0; end
			4'd1:  begin row = 2'd0; col = 2'd1; end
			4'd2:  begin row = 2'd0; col = 2'd2; end
			4'd3:  begin row = 2'd1; col = 2'd0; end
			4'd4:  begin row = 2'd1; col = 2'd1; end
			4'd5:  begin row = 2'd1; col = 2'd2; end
			4'd6:  begin row = 2'd2; col = 2'd0; end
			4'd7:  begin row = 2'd2; col = 2'd1; end
			4'd8:  begin row = 2'd2; col = 2'd2; end
			4'd9:  begin row = 2'd1; col = 2'd1; d1.g.rot = ROT_PLUS;  end
			4'd10: begin row = 2'd1; col = 2'd0; d1.g.rot = ROT_MINUS; end
			4'd11: begin row = 2'd0; col = 2'd1; d1.g.rot = ROT_MINUS; end
			4'd12: begin row = 2'd1; col = 2'd2; d1.g.rot = ROT_MINUS; end
			4'd13: begin row = 2'd2; col = 2'd1; d1.g.rot = ROT_MINUS; end
			default: defined = 1'b0;
		endcase

		// offsets in doubled units so half sizes stay exact
		w1 = OFS_BITS'({2'b00, item.width});
		w2 = OFS_BITS'({1'b0, item.width, 1'b0});
		h1 = OFS_BITS'({2'b00, item.height});
		h2 = OFS_BITS'({1'b0, item.height, 1'b0});

		d1.g.ax = item.anchor_x;
		d1.g.ay = item.anchor_y;
		if (defined) begin
			unique case (col)
				2'd0:    begin d1.g.xo0 = '0;  d1.g.xo1 = w2; end
				2'd1:    begin d1.g.xo0 = -w1; d1.g.xo1 = w1; end
				default: begin d1.g.xo0 = -w2; d1.g.xo1 = '0; end
			endcase
			unique case (row)
				2'd0:    begin d1.g.yo0 = -h2; d1.g.yo1 = '0; end
				2'd1:    begin d1.g.yo0 = -h1; d1.g.yo1 = h1; end
				default: begin d1.g.yo0 = '0;  d1.g.yo1 = h2; end
			endcase
		end

		// angle as a 32-bit turn; cosine is the sine a quarter turn later
		turn    = 32'(item.angle) << (32 - ANGLE_BITS);
		quad[0] = turn[31:30];
		quad[1] = turn[31:30] + 2'd1;
		frac    = turn[29:14];
		for (int i = 0; i < 2; i++) begin
			d1.x[i]   = quad[i][0] ? (Q16_ONE - {1'b0, frac}) : {1'b0, frac};
			d1.neg[i] = quad[i][1];
		end
	end

	// ---------------- stage 2: z = x*x, seed p ----------------
	stage_t d2, st_s2;
	logic   v_s2, rdy_s2;

	always_comb begin
		d2 = st_s1;
		for (int i = 0; i < 2; i++) begin
			d2.z[i] = mulq16(st_s1.x[i], st_s1.x[i]);
			d2.p[i] = SIN_A7;
		end
	end

	// ---------------- stages 3..5: Horner chain ----------------
	stage_t cell_data  [NUM_CELLS+1];
	logic   cell_valid [NUM_CELLS+1];
	logic   cell_ready [NUM_CELLS+1];

	assign cell_data[0]  = st_s2;
	assign cell_valid[0] = v_s2;

	for (genvar k = 0; k < NUM_CELLS; k++) begin : g_cell
		sqcg_horner_cell #(.COEF(HORNER_COEF[k])) u_cell (
			.clk       (clk),
			.arst_n    (arst_n),
			.in_valid  (cell_valid[k]),
			.in_data   (cell_data[k]),
			.in_ready  (cell_ready[k]),
			.out_valid (cell_valid[k+1]),
			.out_data  (cell_data[k+1]),
			.out_ready (cell_ready[k+1])
		);
	end

	// ---------------- stage 6: final scale, clamp, sign, rotation direction ----------------
	stage_t st_c;
	logic   v_s6, rdy_s6;
	geom_t  g_s6;
	logic signed [TRIG_BITS-1:0] sin_s6, cos_s6;
	logic signed [TRIG_BITS-1:0] sv [2];
	logic signed [TRIG_BITS-1:0] sin_d, cos_d;
	mag_t r;

	assign st_c = cell_data[NUM_CELLS];

	always_comb begin
		for (int i = 0; i < 2; i++) begin
			r = mulq16(st_c.p[i], st_c.x[i]);
			if (r > Q16_ONE) begin
				r = Q16_ONE;
			end
			sv[i] = st_c.neg[i] ? -TRIG_BITS'({1'b0, r}) : TRIG_BITS'({1'b0, r});
		end
		unique case (st_c.g.rot)
			ROT_PLUS:  begin sin_d = sv[0];  cos_d = sv[1]; end
			ROT_MINUS: begin sin_d = -sv[0]; cos_d = sv[1]; end
			default:   begin sin_d = '0; cos_d = TRIG_BITS'({1'b0, Q16_ONE}); end
		endcase
	end

	// ---------------- stage 7: rotate products ----------------
	logic v_s7, rdy_s7;
	logic signed [COORD_BITS-1:0] ax_s7, ay_s7;
	logic signed [PROD_BITS-1:0]  xc_s7 [2], xs_s7 [2], yc_s7 [2], ys_s7 [2];

	// ---------------- stage 8: round, add anchor, saturate ----------------
	logic rdy_s8;

	function automatic logic signed [COORD_BITS-1:0] corner(
		input logic signed [COORD_BITS-1:0] a,
		input logic signed [PROD_BITS-1:0]  p0,
		input logic signed [PROD_BITS-1:0]  p1,
		input logic                         sub
	);
		logic signed [PROD_BITS:0]   acc;
		logic signed [PROD_BITS:0]   dsh;
		logic signed [SUM_BITS-1:0]  tot;
		acc = sub ? ({p0[PROD_BITS-1], p0} - {p1[PROD_BITS-1], p1})
		          : ({p0[PROD_BITS-1], p0} + {p1[PROD_BITS-1], p1});
		acc = acc + (PROD_BITS+1)'(65536);
		dsh = acc >>> 17;
		tot = {{(SUM_BITS-COORD_BITS){a[COORD_BITS-1]}}, a} + {dsh[PROD_BITS], dsh};
		if (&tot[SUM_BITS-1:COORD_BITS-1] || !(|tot[SUM_BITS-1:COORD_BITS-1])) begin
			return tot[COORD_BITS-1:0];
		end
		return tot[SUM_BITS-1] ? {1'b1, {(COORD_BITS-1){1'b0}}}
		                       : {1'b0, {(COORD_BITS-1){1'b1}}};
	endfunction

	// ---------------- flow control ----------------
	// A stage loads when it is empty or its word is leaving.
	assign rdy_s8 = !corners_valid || !corners_stall;
	assign rdy_s7 = !v_s7 || rdy_s8;
	assign rdy_s6 = !v_s6 || rdy_s7;
	assign cell_ready[NUM_CELLS] = rdy_s6;
	assign rdy_s2 = !v_s2 || cell_ready[0];
	assign rdy_s1 = !v_s1 || rdy_s2;
	assign item_stall = !rdy_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1          <= 1'b0;
			v_s2          <= 1'b0;
			v_s6          <= 1'b0;
			v_s7          <= 1'b0;
			corners_valid <= 1'b0;
		end else begin
			if (rdy_s1) begin
				v_s1 <= item_valid;
			end
			if (rdy_s2) begin
				v_s2 <= v_s1;
			end
			if (rdy_s6) begin
				v_s6 <= cell_valid[NUM_CELLS];
			end
			if (rdy_s7) begin
				v_s7 <= v_s6;
			end
			if (rdy_s8) begin
				corners_valid <= v_s7;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (rdy_s1) begin
			st_s1 <= d1;
		end
		if (rdy_s2) begin
			st_s2 <= d2;
		end
		if (rdy_s6) begin
			g_s6   <= st_c.g;
			sin_s6 <= sin_d;
			cos_s6 <= cos_d;
		end
		if (rdy_s7) begin
			ax_s7    <= g_s6.ax;
			ay_s7    <= g_s6.ay;
			xc_s7[0] <= g_s6.xo0 * cos_s6;
			xc_s7[1] <= g_s6.xo1 * cos_s6;
			xs_s7[0] <= g_s6.xo0 * sin_s6;
			xs_s7[1] <= g_s6.xo1 * sin_s6;
			yc_s7[0] <= g_s6.yo0 * cos_s6;
			yc_s7[1] <= g_s6.yo1 * cos_s6;
			ys_s7[0] <= g_s6.yo0 * sin_s6;
			ys_s7[1] <= g_s6.yo1 * sin_s6;
		end
		if (rdy_s8) begin
			// x = ox*c - oy*s, y = ox*s + oy*c
			corners.top_left_x     <= corner(ax_s7, xc_s7[0], ys_s7[0], 1'b1);
			corners.top_left_y     <= corner(ay_s7, xs_s7[0], yc_s7[0], 1'b0);
			corners.top_right_x    <= corner(ax_s7, xc_s7[1], ys_s7[0], 1'b1);
			corners.top_right_y    <= corner(ay_s7, xs_s7[1], yc_s7[0], 1'b0);
			corners.bottom_left_x  <= corner(ax_s7, xc_s7[0], ys_s7[1], 1'b1);
			corners.bottom_left_y  <= corner(ay_s7, xs_s7[0], yc_s7[1], 1'b0);
			corners.bottom_right_x <= corner(ax_s7, xc_s7[1], ys_s7[1], 1'b1);
			corners.bottom_right_y <= corner(ay_s7, xs_s7[1], yc_s7[1], 1'b0);
		end
	end

	// ---------------- checks ----------------
	a_accept_loads: assert property (@(posedge clk) disable iff (!arst_n)
		(item_valid && !item_stall) |=> v_s1)
		else $error("accepted word did not reach stage 1");

	a_stall_only_full: assert property (@(posedge clk) disable iff (!arst_n)
		item_stall |-> (v_s1 && v_s2 && v_s6 && v_s7 && corners_valid && corners_stall))
		else $error("input stalled with room in the pipe");

	a_axis_unrotated: assert property (@(posedge clk) disable iff (!arst_n)
		(v_s7 && $past(rdy_s7) && $past(v_s6) && $past(g_s6.rot) == ROT_NONE)
		|-> (ys_s7[0] == '0 && xs_s7[1] == '0))
		else $error("axis-aligned word picked up a sine term");

	a_trig_range: assert property (@(posedge clk) disable iff (!arst_n)
		v_s6 |-> (sin_s6 <= TRIG_BITS'(65536) && sin_s6 >= -TRIG_BITS'(65536)
		          && cos_s6 <= TRIG_BITS'(65536) && cos_s6 >= -TRIG_BITS'(65536)))
		else $error("sine or cosine beyond unity");

endmodule
`default_nettype wire

[sim/tb.sv]
// Testbench for the sprite quad corner generator: random and directed sprites, checked corners.
`default_nettype none
module tb;
	timeunit 1ns;
	timeprecision 1ps;
	import sqcg_pkg::*;

	localparam int MODE_UPPER_RIGHT = 8;
	localparam int MODE_ROT_CENTER  = 9;
	localparam int MODE_ROT_TOP     = 13;
	localparam int MODE_UNDEF_LO    = 14;
	localparam int MODE_UNDEF_HI    = 15;
	localparam int LATENCY          = 8;
	localparam int WATCHDOG_LIMIT   = 2000;
	localparam int NUM_RANDOM       = 1100;
	localparam int QUIET_TAIL       = 150;  // last words driven/drained with no idling
	localparam int HOLD_CYCLES      = 60;   // one long receiver hold-off

	logic     clk;
	logic     arst_n;
	logic     item_valid;
	logic     item_stall;
	item_t    item;
	logic     corners_valid;
	logic     corners_stall;
	corners_t corners;

	sprite_quad_corner_generator_unit dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.item_valid    (item_valid),
		.item_stall    (item_stall),
		.item          (item),
		.corners_valid (corners_valid),
		.corners_stall (corners_stall),
		.corners       (corners)
	);

	item_t    pending_sprites[$];
	corners_t expected_corners[$];
	int       n_errors;
	int       n_sent;
	int       n_total;
	bit       stim_done;

	initial clk = 1'b0;
	always #4 clk = ~clk;

	// ---------------------------------------------------------------------------
	// Corner predictor
	// ---------------------------------------------------------------------------

	// (a*b + 0.5) >> 16, unsigned
	function automatic longint unsigned q16_round_mul(longint unsigned a, longint unsigned b);
		return (a * b + 64'd32768) >> 16;
	endfunction

	// quarter-wave odd polynomial, Horner form, clamped to 1.0
	function automatic longint unsigned quarter_wave(longint unsigned x);
		longint unsigned z, p, r;
		z = q16_round_mul(x, x);
		p = 297;
		p = 5223 - q16_round_mul(p, z);
		p = 42334 - q16_round_mul(p, z);
		p = 102944 - q16_round_mul(p, z);
		r = q16_round_mul(p, x);
		return (r > 65536) ? 65536 : r;
	endfunction

	// signed Q16 sine of a 32-bit turn
	function automatic longint sin_of_turn(logic [31:0] t);
		logic [1:0]      quad;
		longint unsigned f;
		longint          v;
		quad = t[31:30];
		f = t[29:14];
		if (quad[0]) f = 65536 - f;
		v = longint'(quarter_wave(f));
		return quad[1] ? -v : v;
	endfunction

	// arithmetic shift right is a floor for signed values
	function automatic longint floor_div_pow2(longint v, int k);
		return v >>> k;
	endfunction

	function automatic logic signed [COORD_BITS-1:0] clamp_coord(longint v);
		longint hi, lo;
		hi = (longint'(1) <<< (COORD_BITS - 1)) - 1;
		lo = -hi - 1;
		if (v > hi) v = hi;
		if (v < lo) v = lo;
		return v[COORD_BITS-1:0];
	endfunction

	function automatic corners_t predict_corners(item_t it);
		corners_t   res;
		int         mode, row, col, rot, k;
		longint     ax, ay, w, h, s, c, ox, oy, rx, ry;
		longint     xo[2], yo[2];
		longint     cx[4], cy[4];
		logic [31:0] t;
		mode = it.anchor_mode;
		ax = longint'(it.anchor_x);
		ay = longint'(it.anchor_y);
		w = longint'({1'b0, it.width});
		h = longint'({1'b0, it.height});
		t = {it.angle, {(32 - ANGLE_BITS){1'b0}}};
		if (mode >= MODE_UNDEF_LO) begin
			for (k = 0; k < 4; k++) begin
				cx[k] = ax;
				cy[k] = ay;
			end
		end else begin
			if (mode <= MODE_UPPER_RIGHT) begin
				row = mode / 3;
				col = mode % 3;
				rot = 0;
			end else begin
				case (mode - MODE_ROT_CENTER)
					0: begin row = 1; col = 1; end
					1: begin row = 1; col = 0; end
					2: begin row = 0; col = 1; end
					3: begin row = 1; col = 2; end
					default: begin row = 2; col = 1; end
				endcase
				rot = (mode == MODE_ROT_CENTER) ? 1 : -1;
			end
			// doubled units so half sizes are exact
			case (col)
				0: begin xo[0] = 0; xo[1] = 2 * w; end
				1: begin xo[0] = -w; xo[1] = w; end
				default: begin xo[0] = -2 * w; xo[1] = 0; end
			endcase
			case (row)
				0: begin yo[0] = -2 * h; yo[1] = 0; end
				1: begin yo[0] = -h; yo[1] = h; end
				default: begin yo[0] = 0; yo[1] = 2 * h; end
			endcase
			if (rot == 0) begin
				s = 0;
				c = 65536;
			end else begin
				s = sin_of_turn(t);
				c = sin_of_turn(t + 32'h4000_0000);
				if (rot < 0) s = -s;
			end
			for (k = 0; k < 4; k++) begin
				ox = xo[k & 1];
				oy = yo[k >> 1];
				rx = ox * c - oy * s;
				ry = ox * s + oy * c;
				cx[k] = ax + floor_div_pow2(rx + 65536, 17);
				cy[k] = ay + floor_div_pow2(ry + 65536, 17);
			end
		end
		res.top_left_x     = clamp_coord(cx[0]);
		res.top_left_y     = clamp_coord(cy[0]);
		res.top_right_x    = clamp_coord(cx[1]);
		res.top_right_y    = clamp_coord(cy[1]);
		res.bottom_left_x  = clamp_coord(cx[2]);
		res.bottom_left_y  = clamp_coord(cy[2]);
		res.bottom_right_x = clamp_coord(cx[3]);
		res.bottom_right_y = clamp_coord(cy[3]);
		return res;
	endfunction

	// ---------------------------------------------------------------------------
	// Stimulus
	// ---------------------------------------------------------------------------

	function automatic item_t make_sprite(int mode, longint x, longint y, longint w,
		longint h, int ang);
		item_t it;
		it.anchor_mode = mode[3:0];
		it.anchor_x    = x[COORD_BITS-1:0];
		it.anchor_y    = y[COORD_BITS-1:0];
		it.width       = w[COORD_BITS-2:0];
		it.height      = h[COORD_BITS-2:0];
		it.angle       = ang[ANGLE_BITS-1:0];
		return it;
	endfunction

	// mostly modest coordinates and sizes, sometimes full range to hit saturation
	function automatic longint rand_coord();
		case ($urandom_range(3))
			0: return longint'($signed($urandom_range(24'hFFFFFF) << 8) >>> 8);
			1: return longint'($urandom_range(0, 2 ** 18)) - (2 ** 17);
			2: return $urandom_range(1) ? 8388607 - $urandom_range(4096)
				: -8388608 + $urandom_range(4096);
			default: return longint'($urandom_range(0, 4096)) - 2048;
		endcase
	endfunction

	function automatic longint rand_size();
		case ($urandom_range(3))
			0: return $urandom_range(23'h7FFFFF);
			1: return $urandom_range(0, 2 ** 16);
			2: return 23'h7FFFFF - $urandom_range(255);
			default: return $urandom_range(0, 64);
		endcase
	endfunction

	function automatic int rand_angle();
		case ($urandom_range(4))
			0: return $urandom_range(3) * 16384;
			1: return ($urandom_range(3) * 16384 + $urandom_range(2) - 1) & 16'hFFFF;
			default: return $urandom_range(16'hFFFF);
		endcase
	endfunction

	initial begin
		int m;
		n_errors = 0;
		stim_done = 1'b0;
		// directed: every mode at small sizes/coordinates, then some modes at extreme ones
		for (m = 0; m <= MODE_UNDEF_HI; m++)
			pending_sprites.push_back(make_sprite(m, 256, -512, 7, 5, 8192));
		pending_sprites.push_back(make_sprite(4, 8388607, -8388608, 23'h7FFFFF, 23'h7FFFFF, 0));
		pending_sprites.push_back(make_sprite(MODE_ROT_CENTER, -8388608, 8388607,
			23'h7FFFFF, 23'h7FFFFF, 16'hFFFF));
		pending_sprites.push_back(make_sprite(MODE_ROT_TOP, 0, 0, 23'h7FFFFF, 1, 16384));
		pending_sprites.push_back(make_sprite(10, 100, 100, 0, 0, 12345));
		pending_sprites.push_back(make_sprite(11, 0, 0, 3, 3, 32768));
		pending_sprites.push_back(make_sprite(12, 0, 0, 1000, 2000, 49152));
		pending_sprites.push_back(make_sprite(MODE_UNDEF_HI, -8388608, 8388607, 23'h7FFFFF,
			23'h7FFFFF, 16'hFFFF));
		pending_sprites.push_back(make_sprite(1, 0, 0, 1, 1, 1));
		for (int i = 0; i < NUM_RANDOM; i++) begin
			// undefined modes only now and then
			m = ($urandom_range(15) == 0) ? $urandom_range(MODE_UNDEF_LO, MODE_UNDEF_HI)
				: $urandom_range(MODE_ROT_TOP);
			pending_sprites.push_back(make_sprite(m, rand_coord(), rand_coord(), rand_size(),
				rand_size(), rand_angle()));
		end
		n_total = pending_sprites.size();
		stim_done = 1'b1;
	end

	// ---------------------------------------------------------------------------
	// Reset
	// ---------------------------------------------------------------------------
	initial begin
		arst_n = 1'b0;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
	end

	// ---------------------------------------------------------------------------
	// Driver: pops the next word, idles in bursts, holds payload while stalled
	// ---------------------------------------------------------------------------
	int send_gap;
	initial begin
		item_valid = 1'b0;
		item = '0;
		send_gap = 0;
		n_sent = 0;
	end

	always @(posedge clk) begin
		if (arst_n && stim_done) begin
			// accepted this edge (or nothing on offer): choose what to offer next
			if (!item_valid || !item_stall) begin
				if (item_valid) begin
					expected_corners.push_back(predict_corners(item));
					n_sent <= n_sent + 1;
				end
				if (send_gap > 0) begin
					send_gap <= send_gap - 1;
					item_valid <= 1'b0;
				end else if (pending_sprites.size() > 0) begin
					item <= pending_sprites.pop_front();
					item_valid <= 1'b1;
					// bursts of idling, except in the quiet tail
					if (pending_sprites.size() > QUIET_TAIL && $urandom_range(9) == 0)
						send_gap <= $urandom_range(1, 7);
				end else begin
					item_valid <= 1'b0;
				end
			end
		end
	end

	// ---------------------------------------------------------------------------
	// Receiver: random stall bursts plus one long hold-off to back up the pipe
	// ---------------------------------------------------------------------------
	int  stall_left;
	int  hold_left;
	bit  hold_done;
	int  n_received;
	initial begin
		corners_stall = 1'b0;
		stall_left = 0;
		hold_left = 0;
		hold_done = 1'b0;
		n_received = 0;
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if (!hold_done && n_received == 100) begin
				hold_done <= 1'b1;
				hold_left <= HOLD_CYCLES;
				corners_stall <= 1'b1;
			end else if (hold_left > 0) begin
				hold_left <= hold_left - 1;
				corners_stall <= (hold_left > 1);
			end else if (stall_left > 0) begin
				stall_left <= stall_left - 1;
				corners_stall <= (stall_left > 1);
			end else if (n_received < n_total - QUIET_TAIL && $urandom_range(7) == 0) begin
				stall_left <= $urandom_range(1, 7);
				corners_stall <= 1'b1;
			end else begin
				corners_stall <= 1'b0;
			end
		end
	end

	// ---------------------------------------------------------------------------
	// Monitor: compare each accepted corner word with the oldest prediction
	// ---------------------------------------------------------------------------
	task automatic check_field(string name, logic [COORD_BITS-1:0] exp_v,
		logic [COORD_BITS-1:0] act_v);
		if (exp_v !== act_v) begin
			$error("%s mismatch: expected %0d actual %0d", name, $signed(exp_v),
				$signed(act_v));
			n_errors++;
		end
	endtask

	always @(posedge clk) begin
		corners_t exp_c;
		if (arst_n && corners_valid && !corners_stall) begin
			n_received <= n_received + 1;
			if (expected_corners.size() == 0) begin
				$error("corner word with no sprite outstanding");
				n_errors++;
			end else begin
				exp_c = expected_corners.pop_front();
				check_field("top_left_x", exp_c.top_left_x, corners.top_left_x);
				check_field("top_left_y", exp_c.top_left_y, corners.top_left_y);
				check_field("top_right_x", exp_c.top_right_x, corners.top_right_x);
				check_field("top_right_y", exp_c.top_right_y, corners.top_right_y);
				check_field("bottom_left_x", exp_c.bottom_left_x, corners.bottom_left_x);
				check_field("bottom_left_y", exp_c.bottom_left_y, corners.bottom_left_y);
				check_field("bottom_right_x", exp_c.bottom_right_x, corners.bottom_right_x);
				check_field("bottom_right_y", exp_c.bottom_right_y, corners.bottom_right_y);
			end
		end
	end

	// ---------------------------------------------------------------------------
	// Watchdog and end of run
	// ---------------------------------------------------------------------------
	int idle_cycles;
	initial idle_cycles = 0;

	always @(posedge clk) begin
		if ((item_valid && !item_stall) || (corners_valid && !corners_stall))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
	end

	initial begin
		wait (stim_done);
		@(posedge clk);
		while (!(pending_sprites.size() == 0 && !item_valid && expected_corners.size() == 0)
			&& idle_cycles < WATCHDOG_LIMIT)
			@(posedge clk);
		if (idle_cycles >= WATCHDOG_LIMIT) begin
			$display("== FAIL ==");
		end else begin
			// let any stray word surface
			repeat (LATENCY * 4) @(posedge clk);
			if (n_errors == 0) begin
				$display("== PASS ==");
			end else begin
				$display("== FAIL ==");
			end
		end
		$finish;
	end

endmodule
`default_nettype wire

[sprite_quad_corner_generator_unit.f]
sv/sqcg_pkg.sv
sv/sqcg_horner_cell.sv
sv/sprite_quad_corner_generator_unit.sv
sim/tb.sv
